// ===== hdl/htr_pkg.sv =====
// Shared types, constants and controller encodings of the hysteresis tachometer core.
package htr_pkg;

    localparam int SAMPLE_W = 12;
    localparam int TIME_W   = 32;
    localparam int RPM_W    = 26;
    localparam int SPEED_W  = 39;
    localparam int ACCEL_W  = 40;
    localparam int PROD_W   = 60;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 144;

    localparam int DIV_NUM_W = 43;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam int PI_HALF_W  = 17;
    localparam int SPEED_SHIFT = 17;

    localparam int SPD_DIGIT_W = 4;
    localparam int SPD_STEPS   = 12;
    localparam int SPD_CNT_W   = $clog2(SPD_STEPS + 1);

    localparam logic [RPM_W-1:0]       RPM_NUMERATOR = RPM_W'(60000000);
    localparam logic [2*PI_HALF_W-1:0] PI_Q32        = 34'h3243F6A88;
    localparam logic [DIV_NUM_W-1:0]   SPEED_DIV_ODD = DIV_NUM_W'(15);

    localparam logic [SAMPLE_W-1:0] HIGH_THR_RESET = SAMPLE_W'(3000);
    localparam logic [SAMPLE_W-1:0] LOW_THR_RESET  = SAMPLE_W'(1000);

    localparam logic CFG_HIGH_THR = 1'b0;
    localparam logic CFG_LOW_THR  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RPM_DIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SPD_START,
        ST_SPD_DIV,
        ST_ACC_PREP,
        ST_ACC_START,
        ST_ACC_DIV,
        ST_DONE
    } htr_state_t;

    typedef enum logic [1:0] {
        SEL_RPM,
        SEL_ACC
    } htr_div_sel_t;

    typedef struct packed {
        logic         accept;
        logic         div_start;
        htr_div_sel_t div_sel;
        logic         take_rpm;
        logic         mul_lo;
        logic         mul_hi;
        logic         spd_start;
        logic         take_spd;
        logic         acc_prep;
        logic         take_acc;
        logic         load_out;
    } htr_cmd_t;

    typedef struct packed {
        logic edge_in;
        logic period_in_zero;
        logic period_zero;
        logic div_done;
        logic spd_done;
        logic out_free;
    } htr_stat_t;

endpackage

// ===== hdl/htr_div.sv =====
// Radix-2 restoring divider that retires one quotient bit per clock cycle.
module htr_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [htr_pkg::DIV_NUM_W-1:0]  numerator,
    input  logic [htr_pkg::DIV_DEN_W-1:0]  denominator,
    output logic [htr_pkg::DIV_NUM_W-1:0]  quotient,
    output logic                           done
);
    import htr_pkg::*;

    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= numerator;
            rem_reg <= '0;
            den_reg <= denominator;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== hdl/htr_datapath.sv =====
// Datapath: thresholds, edge detection state, multiplier, speed scaling, shared divider and result register.
module htr_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [htr_pkg::SAMPLE_W-1:0]  cfg_data,
    input  logic [htr_pkg::S_DATA_W-1:0]  s_tdata,
    output logic [htr_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  htr_pkg::htr_cmd_t             cmd,
    output htr_pkg::htr_stat_t            status
);
    import htr_pkg::*;

    logic [SAMPLE_W-1:0] high_thr_reg;
    logic [SAMPLE_W-1:0] low_thr_reg;
    logic                armed_reg;
    logic [TIME_W-1:0]   last_time_reg;
    logic [SPEED_W-1:0]  last_speed_reg;

    logic [TIME_W-1:0]   period_reg;
    logic [RPM_W-1:0]    rpm_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SPEED_W-1:0]  speed_reg;
    logic [ACCEL_W-1:0]  accel_reg;
    logic                neg_reg;
    logic [SPEED_W-1:0]  mag_reg;

    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic [DIV_NUM_W-1:0] spd_quo_reg;
    logic [DIV_NUM_W-1:0] spd_rem_reg;
    logic [SPD_CNT_W-1:0] spd_cnt_reg;
    logic                 spd_busy_reg;
    logic                 spd_done_reg;
    logic [DIV_NUM_W-1:0] spd_rem_hi;
    logic [DIV_NUM_W-1:0] spd_rem_lo;
    logic [DIV_NUM_W-1:0] spd_quo;

    logic [SAMPLE_W-1:0] in_sample;
    logic [TIME_W-1:0]   in_time;
    logic [TIME_W-1:0]   period_in;
    logic                edge_in;

    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quo;
    logic                 div_done;

    assign in_sample = s_tdata[SAMPLE_W-1:0];
    assign in_time   = s_tdata[SAMPLE_W +: TIME_W];
    assign period_in = in_time - last_time_reg;
    assign edge_in   = armed_reg && (in_sample > high_thr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_thr_reg   <= HIGH_THR_RESET;
            low_thr_reg    <= LOW_THR_RESET;
            armed_reg      <= 1'b0;
            last_time_reg  <= '0;
            last_speed_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_HIGH_THR: high_thr_reg <= cfg_data;
                    CFG_LOW_THR:  low_thr_reg  <= cfg_data;
                    default:      high_thr_reg <= high_thr_reg;
                endcase
            end
            if (cmd.accept) begin
                if (in_sample < low_thr_reg) begin
                    armed_reg <= 1'b1;
                end else if (edge_in) begin
                    armed_reg <= 1'b0;
                end
                if (edge_in) begin
                    last_time_reg <= in_time;
                end
            end
            if (cmd.load_out) begin
                last_speed_reg <= speed_reg;
                out_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Division by fifteen: since sixteen leaves one over fifteen, each step moves the upper
    // digits of the remainder into the quotient and folds them back onto the low digit.
    assign spd_rem_hi = DIV_NUM_W'(spd_rem_reg[DIV_NUM_W-1:SPD_DIGIT_W]);
    assign spd_rem_lo = DIV_NUM_W'(spd_rem_reg[SPD_DIGIT_W-1:0]);
    assign spd_quo    = spd_quo_reg
                      + {{(DIV_NUM_W-1){1'b0}}, (spd_rem_reg == SPEED_DIV_ODD)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spd_busy_reg <= 1'b0;
            spd_done_reg <= 1'b0;
            spd_cnt_reg  <= '0;
        end else begin
            spd_done_reg <= 1'b0;
            if (cmd.spd_start) begin
                spd_busy_reg <= 1'b1;
                spd_cnt_reg  <= SPD_CNT_W'(SPD_STEPS);
            end else if (spd_busy_reg) begin
                spd_cnt_reg <= spd_cnt_reg - 1'b1;
                if (spd_cnt_reg == SPD_CNT_W'(1)) begin
                    spd_busy_reg <= 1'b0;
                    spd_done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        div_num = DIV_NUM_W'(RPM_NUMERATOR);
        div_den = period_in;
        case (cmd.div_sel)
            SEL_RPM: begin
                div_num = DIV_NUM_W'(RPM_NUMERATOR);
                div_den = period_in;
            end
            SEL_ACC: begin
                div_num = DIV_NUM_W'(mag_reg);
                div_den = period_reg;
            end
            default: begin
                div_num = DIV_NUM_W'(RPM_NUMERATOR);
                div_den = period_in;
            end
        endcase
    end

    htr_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (cmd.div_start),
        .numerator   (div_num),
        .denominator (div_den),
        .quotient    (div_quo),
        .done        (div_done)
    );

    always_ff @(posedge aclk) begin
        if (cmd.accept && edge_in) begin
            period_reg <= period_in;
            rpm_reg    <= RPM_NUMERATOR;
        end
        if (cmd.take_rpm) begin
            rpm_reg <= div_quo[RPM_W-1:0];
        end
        if (cmd.mul_lo) begin
            prod_reg <= PROD_W'(rpm_reg * PI_Q32[PI_HALF_W-1:0]);
        end
        if (cmd.mul_hi) begin
            prod_reg <= prod_reg
                      + (PROD_W'(rpm_reg * PI_Q32[2*PI_HALF_W-1:PI_HALF_W]) << PI_HALF_W);
        end
        if (cmd.spd_start) begin
            spd_quo_reg <= '0;
            spd_rem_reg <= prod_reg[SPEED_SHIFT +: DIV_NUM_W];
        end else if (spd_busy_reg) begin
            spd_quo_reg <= spd_quo_reg + spd_rem_hi;
            spd_rem_reg <= spd_rem_hi + spd_rem_lo;
        end
        if (cmd.take_spd) begin
            speed_reg <= spd_quo[SPEED_W-1:0];
            accel_reg <= '0;
        end
        if (cmd.acc_prep) begin
            neg_reg <= speed_reg < last_speed_reg;
            mag_reg <= (speed_reg < last_speed_reg) ? (last_speed_reg - speed_reg)
                                                    : (speed_reg - last_speed_reg);
        end
        if (cmd.take_acc) begin
            accel_reg <= neg_reg ? (ACCEL_W'(0) - ACCEL_W'(div_quo[SPEED_W-1:0]))
                                 : ACCEL_W'(div_quo[SPEED_W-1:0]);
        end
        if (cmd.load_out) begin
            out_data_reg <= M_DATA_W'({accel_reg, speed_reg, rpm_reg, period_reg});
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

    assign status.edge_in        = edge_in;
    assign status.period_in_zero = (period_in == '0);
    assign status.period_zero    = (period_reg == '0);
    assign status.div_done       = div_done;
    assign status.spd_done       = spd_done_reg;
    assign status.out_free       = !out_valid_reg || m_tready;

endmodule

// ===== hdl/htr_ctrl.sv =====
// Controller state machine that sequences one rising-edge computation.
module htr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  htr_pkg::htr_stat_t  status,
    output htr_pkg::htr_cmd_t   cmd
);
    import htr_pkg::*;

    htr_state_t state_reg;
    htr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = SEL_RPM;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (status.edge_in) begin
                        if (status.period_in_zero) begin
                            state_next = ST_MUL_LO;
                        end else begin
                            cmd.div_start = 1'b1;
                            cmd.div_sel   = SEL_RPM;
                            state_next    = ST_RPM_DIV;
                        end
                    end
                end
            end
            ST_RPM_DIV: begin
                if (status.div_done) begin
                    cmd.take_rpm = 1'b1;
                    state_next   = ST_MUL_LO;
                end
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_SPD_START;
            end
            ST_SPD_START: begin
                cmd.spd_start = 1'b1;
                state_next    = ST_SPD_DIV;
            end
            ST_SPD_DIV: begin
                if (status.spd_done) begin
                    cmd.take_spd = 1'b1;
                    if (status.period_zero) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_ACC_PREP;
                    end
                end
            end
            ST_ACC_PREP: begin
                cmd.acc_prep = 1'b1;
                state_next   = ST_ACC_START;
            end
            ST_ACC_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_ACC;
                state_next    = ST_ACC_DIV;
            end
            ST_ACC_DIV: begin
                if (status.div_done) begin
                    cmd.take_acc = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/hysteresis_tachometer_rpm_core.sv =====
// Top level of the hysteresis tachometer: controller, datapath and stream ports.
//
// Each input transaction carries one sensor sample and its microsecond timestamp. A sample
// below the low threshold arms the detector; an armed sample above the high threshold is a
// rising edge and produces one result transaction with period, RPM, angular speed and
// angular acceleration. A sample that is not an edge leaves the block ready for the next
// sample. An edge occupies the block from its acceptance to the next possible acceptance:
// the shared radix-2 divider runs 43 steps each for the RPM quotient and the acceleration
// quotient, the speed scaling takes a 12-step shift-and-add division by fifteen, and a
// split multiply, low half then high half, sits in between. With a zero period both
// quotients are skipped. An edge also stalls before loading its result while the previous
// result still waits for m_tready. The result waits in an output register, so the next
// sample is accepted while it is still pending. Configuration writes take effect at once
// and should be made while idle.
module hysteresis_tachometer_rpm_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [htr_pkg::SAMPLE_W-1:0]  cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0: sample[11:0], time_us[43:12], zero fill to 48 bits.
    input  logic [htr_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0: period_us[31:0], rpm[57:32], speed_rad_s[96:58], accel[136:97].
    output logic [htr_pkg::M_DATA_W-1:0]  m_tdata
);
    import htr_pkg::*;

    htr_cmd_t  cmd;
    htr_stat_t status;

    htr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    htr_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("Result loaded while the output register is still occupied.");

    a_edge_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && status.edge_in) |=> !s_tready)
        else $error("Input accepted again before the edge computation finished.");

    a_div_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> !s_tready)
        else $error("Divider finished while the block was idle.");

endmodule
